[rtl/core/tcspq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the two-class strict priority queue.
package tcspq_pkg;

  // Stored descriptor: tag in the upper half, length in the lower half.
  localparam int unsigned EntryW   = 32;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned PktLimW  = 8;
  localparam int unsigned ByteLimW = 23;
  localparam int unsigned PortW    = 16;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // Register reset values.
  localparam logic                LimitByBytesRst = 1'b0;
  localparam logic [PktLimW-1:0]  PktLimitRst     = 8'd100;
  localparam logic [ByteLimW-1:0] ByteLimitRst    = 23'd6553500;
  localparam logic [PortW-1:0]    PrioPortRst     = 16'd3000;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2
  } op_e;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_LIMIT_BY_BYTES    = 3'd0,
    REG_HIGH_PACKET_LIMIT = 3'd1,
    REG_LOW_PACKET_LIMIT  = 3'd2,
    REG_HIGH_BYTE_LIMIT   = 3'd3,
    REG_LOW_BYTE_LIMIT    = 3'd4,
    REG_PRIORITY_PORT     = 3'd5
  } cfg_reg_e;

  // Class codes as carried in out_class.
  localparam logic ClassHigh = 1'b0;
  localparam logic ClassLow  = 1'b1;

  // Per-class command from the admission logic to one descriptor FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  // One result beat; accepted sits in the lowest bit.
  typedef struct packed {
    logic [FieldW-1:0] out_len;
    logic [FieldW-1:0] out_tag;
    logic              out_class;
    logic              out_valid;
    logic              dropped;
    logic              accepted;
  } result_t;

endpackage

[rtl/core/tcspq_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port and one registered read port.
module tcspq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tcspq_fifo.sv]
`timescale 1ns / 1ps
// One descriptor class: RAM-backed FIFO with a head register and byte total.
module tcspq_fifo #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tcspq_pkg::fifo_cmd_t                  cmd_i,
  input  logic [tcspq_pkg::EntryW-1:0]          wdata_i,
  output logic [$clog2(DEPTH+1)-1:0]            count_o,
  output logic [$clog2(DEPTH)+tcspq_pkg::FieldW-1:0] bytes_o,
  output logic [tcspq_pkg::EntryW-1:0]          front_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned BW = AW + tcspq_pkg::FieldW;
  localparam int unsigned EW = tcspq_pkg::EntryW;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, raddr;
  logic [CW-1:0] count_q, count_d;
  logic [BW-1:0] bytes_q, bytes_d, pop_len;
  logic [EW-1:0] front_q, front_d, rdata, second;
  logic          byp_q, byp_d;
  logic [EW-1:0] byp_data_q;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    wrap_inc = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  // Entry behind the head: last cycle's RAM read, or a write that hit it.
  assign second  = byp_q ? byp_data_q : rdata;
  assign pop_len = BW'(front_q[tcspq_pkg::FieldW-1:0]);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    bytes_d = bytes_q;
    front_d = front_q;
    if (cmd_i.push) begin
      tail_d  = wrap_inc(tail_q);
      count_d = count_q + CW'(1);
      bytes_d = bytes_q + BW'(wdata_i[tcspq_pkg::FieldW-1:0]);
      if (count_q == '0) begin
        front_d = wdata_i;
      end
    end else if (cmd_i.pop) begin
      head_d  = wrap_inc(head_q);
      count_d = count_q - CW'(1);
      bytes_d = (bytes_q >= pop_len) ? bytes_q - pop_len : '0;
      front_d = second;
    end
  end

  // Always prefetch the slot after the next head.
  assign raddr = wrap_inc(head_d);
  assign byp_d = cmd_i.push && (tail_q == raddr);

  tcspq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(tail_q),
    .wdata_i(wdata_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      bytes_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      bytes_q <= bytes_d;
      byp_q   <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q    <= front_d;
    byp_data_q <= wdata_i;
  end

  assign count_o = count_q;
  assign bytes_o = bytes_q;
  assign front_o = front_q;

  // Occupancy never passes the physical depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fifo count above depth");

  // An empty FIFO has its head and tail pointers equal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty fifo with pointers apart");

  // A push never lands on a full FIFO and never comes together with a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q != CW'(DEPTH)) && !cmd_i.pop)
    else $error("push into full fifo or push with pop");

endmodule

[rtl/core/two_class_strict_priority_queue_core.sv]
`timescale 1ns / 1ps
// Throughput: one enqueue, dequeue or peek per cycle while the skid entry is free; head
//   registers with a prefetched RAM read keep back-to-back pops at full rate, a two-entry
//   output buffer absorbs stalls; results land in the output register or skid entry.
// Reset (rst_ni, async low): both classes empty, byte totals zero, registers to defaults;
//   the descriptor RAMs are not cleared and need no sweep.
// Top level of the two-class strict priority descriptor queue.
module two_class_strict_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Command stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] port_valid, [16:1] dest_port, [32:17] pkt_len, [48:33] pkt_tag, [55:49] zero
  input  logic [55:0]                        s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                         s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] accepted, [1] dropped, [2] out_valid, [3] out_class,
  // [19:4] out_tag, [35:20] out_len, [39:36] zero
  output logic [39:0]                        m_axis_tdata,
  // Register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcspq_pkg::ApbAddrW-1:0]     paddr,
  input  logic [tcspq_pkg::ApbDataW-1:0]     pwdata,
  output logic [tcspq_pkg::ApbDataW-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned FW    = tcspq_pkg::FieldW;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BW    = $clog2(QUEUE_DEPTH) + FW;
  localparam int unsigned CMPCW = (CW > tcspq_pkg::PktLimW) ? CW : tcspq_pkg::PktLimW;
  localparam int unsigned SUMW  =
    ((BW > tcspq_pkg::ByteLimW) ? BW : tcspq_pkg::ByteLimW) + 1;

  // ---------------------------------------------------------------------------
  // Registers. Writes complete in the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  logic                              by_bytes_q;
  logic [tcspq_pkg::PktLimW-1:0]     high_pkt_lim_q, low_pkt_lim_q;
  logic [tcspq_pkg::ByteLimW-1:0]    high_byte_lim_q, low_byte_lim_q;
  logic [tcspq_pkg::PortW-1:0]       prio_port_q;
  logic                              cfg_we;
  tcspq_pkg::cfg_reg_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = tcspq_pkg::cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      by_bytes_q      <= tcspq_pkg::LimitByBytesRst;
      high_pkt_lim_q  <= tcspq_pkg::PktLimitRst;
      low_pkt_lim_q   <= tcspq_pkg::PktLimitRst;
      high_byte_lim_q <= tcspq_pkg::ByteLimitRst;
      low_byte_lim_q  <= tcspq_pkg::ByteLimitRst;
      prio_port_q     <= tcspq_pkg::PrioPortRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        tcspq_pkg::REG_LIMIT_BY_BYTES:    by_bytes_q      <= pwdata[0];
        tcspq_pkg::REG_HIGH_PACKET_LIMIT: high_pkt_lim_q  <= pwdata[7:0];
        tcspq_pkg::REG_LOW_PACKET_LIMIT:  low_pkt_lim_q   <= pwdata[7:0];
        tcspq_pkg::REG_HIGH_BYTE_LIMIT:   high_byte_lim_q <= pwdata[22:0];
        tcspq_pkg::REG_LOW_BYTE_LIMIT:    low_byte_lim_q  <= pwdata[22:0];
        tcspq_pkg::REG_PRIORITY_PORT:     prio_port_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tcspq_pkg::REG_LIMIT_BY_BYTES:    prdata = 32'(by_bytes_q);
      tcspq_pkg::REG_HIGH_PACKET_LIMIT: prdata = 32'(high_pkt_lim_q);
      tcspq_pkg::REG_LOW_PACKET_LIMIT:  prdata = 32'(low_pkt_lim_q);
      tcspq_pkg::REG_HIGH_BYTE_LIMIT:   prdata = 32'(high_byte_lim_q);
      tcspq_pkg::REG_LOW_BYTE_LIMIT:    prdata = 32'(low_byte_lim_q);
      tcspq_pkg::REG_PRIORITY_PORT:     prdata = 32'(prio_port_q);
      default:                          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  logic                 s_fire;
  tcspq_pkg::op_e       op;
  logic                 port_valid;
  logic [FW-1:0]        dest_port, pkt_len, pkt_tag;

  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign op         = tcspq_pkg::op_e'(s_axis_tuser);
  assign port_valid = s_axis_tdata[0];
  assign dest_port  = s_axis_tdata[16:1];
  assign pkt_len    = s_axis_tdata[32:17];
  assign pkt_tag    = s_axis_tdata[48:33];

  // ---------------------------------------------------------------------------
  // Class FIFOs
  // ---------------------------------------------------------------------------
  tcspq_pkg::fifo_cmd_t              high_cmd, low_cmd;
  logic [CW-1:0]                     high_count, low_count;
  logic [BW-1:0]                     high_bytes, low_bytes;
  logic [tcspq_pkg::EntryW-1:0]      high_front, low_front, new_entry;

  assign new_entry = {pkt_tag, pkt_len};

  tcspq_fifo #(.DEPTH(QUEUE_DEPTH)) u_high_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (high_cmd),
    .wdata_i(new_entry),
    .count_o(high_count),
    .bytes_o(high_bytes),
    .front_o(high_front)
  );

  tcspq_fifo #(.DEPTH(QUEUE_DEPTH)) u_low_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (low_cmd),
    .wdata_i(new_entry),
    .count_o(low_count),
    .bytes_o(low_bytes),
    .front_o(low_front)
  );

  // ---------------------------------------------------------------------------
  // Classify, admit, select. All of it works on the beat as it is taken.
  // ---------------------------------------------------------------------------
  logic                              is_high, admit, cls_full;
  logic [CW-1:0]                     cls_count;
  logic [BW-1:0]                     cls_bytes;
  logic [tcspq_pkg::PktLimW-1:0]     cls_pkt_lim;
  logic [tcspq_pkg::ByteLimW-1:0]    cls_byte_lim;
  logic [SUMW-1:0]                   byte_sum;
  logic                              high_nonempty, low_nonempty;
  tcspq_pkg::result_t                res;

  assign is_high      = port_valid && (dest_port == prio_port_q);
  assign cls_count    = is_high ? high_count : low_count;
  assign cls_bytes    = is_high ? high_bytes : low_bytes;
  assign cls_pkt_lim  = is_high ? high_pkt_lim_q : low_pkt_lim_q;
  assign cls_byte_lim = is_high ? high_byte_lim_q : low_byte_lim_q;
  assign cls_full     = (cls_count == CW'(QUEUE_DEPTH));
  assign byte_sum     = SUMW'(cls_bytes) + SUMW'(pkt_len);

  // Physical depth always bounds a class, whatever the configured limit.
  always_comb begin
    if (cls_full) begin
      admit = 1'b0;
    end else if (by_bytes_q) begin
      admit = byte_sum < SUMW'(cls_byte_lim);
    end else begin
      admit = CMPCW'(cls_count) < CMPCW'(cls_pkt_lim);
    end
  end

  assign high_nonempty = (high_count != '0);
  assign low_nonempty  = (low_count != '0);

  always_comb begin
    res      = '0;
    high_cmd = '0;
    low_cmd  = '0;
    case (op)
      tcspq_pkg::OP_ENQUEUE: begin
        res.out_class = is_high ? tcspq_pkg::ClassHigh : tcspq_pkg::ClassLow;
        res.accepted  = admit;
        res.dropped   = !admit;
        high_cmd.push = s_fire && admit && is_high;
        low_cmd.push  = s_fire && admit && !is_high;
      end
      tcspq_pkg::OP_DEQUEUE, tcspq_pkg::OP_PEEK: begin
        // Strict priority: high class whenever it holds anything.
        if (high_nonempty) begin
          res.out_valid = 1'b1;
          res.out_class = tcspq_pkg::ClassHigh;
          res.out_tag   = high_front[31:16];
          res.out_len   = high_front[15:0];
          high_cmd.pop  = s_fire && (op == tcspq_pkg::OP_DEQUEUE);
        end else if (low_nonempty) begin
          res.out_valid = 1'b1;
          res.out_class = tcspq_pkg::ClassLow;
          res.out_tag   = low_front[31:16];
          res.out_len   = low_front[15:0];
          low_cmd.pop   = s_fire && (op == tcspq_pkg::OP_DEQUEUE);
        end
      end
      default: ;  // unused code: all-zero result, no state change
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry. Input ready depends only on the skid
  // being free, so the result side never stalls the command side combinationally.
  // ---------------------------------------------------------------------------
  tcspq_pkg::result_t out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               out_free;

  assign s_axis_tready = !skid_valid_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || s_fire;
      skid_valid_q <= skid_valid_q && s_fire;
    end else if (s_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
      if (skid_valid_q) begin
        skid_q <= res;
      end
    end else if (s_fire) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Skid entry only fills behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with output empty");

  // An enqueue result is exactly one of accepted or dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.out_valid |-> !(out_q.accepted && out_q.dropped))
    else $error("result both accepted and dropped");

  // A dequeue only touches the low class when the high class is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_cmd.pop |-> !high_nonempty && !high_cmd.pop)
    else $error("low class popped ahead of high class");

  // A dequeue that finds the high class non-empty removes one entry from it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (op == tcspq_pkg::OP_DEQUEUE) && high_nonempty
      |=> high_count == $past(high_count) - CW'(1))
    else $error("high class dequeue lost");

endmodule

[sim/two_class_strict_priority_queue_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench: directed and random command beats scored against a built-in queue model.
module two_class_strict_priority_queue_core_tb;
  import tcspq_pkg::*;

  localparam int unsigned QDepth      = 128;
  localparam int unsigned QuietLimit  = 20000;  // cycles with no beat on any port
  localparam int unsigned LongHold    = 400;    // receiver hold-off used to fill the block
  localparam logic [1:0]  OpUnused    = 2'd3;   // func code with no defined operation

  // One command beat as the bench sees it.
  typedef struct packed {
    logic [1:0]        func;
    logic              port_valid;
    logic [PortW-1:0]  dest_port;
    logic [FieldW-1:0] pkt_len;
    logic [FieldW-1:0] pkt_tag;
  } cmd_beat_t;

  typedef enum int {
    TR_STEADY,
    TR_SENDER_GAPS,
    TR_RECEIVER_STALLS,
    TR_BOTH
  } traffic_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [55:0]         s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  two_class_strict_priority_queue_core #(
    .QUEUE_DEPTH(QDepth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue model: register copies, two descriptor FIFOs and their byte totals.
  // Entries are {tag, len} like the RAM words of the block.
  // ---------------------------------------------------------------------------
  logic                cfg_by_bytes  = LimitByBytesRst;
  logic [PktLimW-1:0]  cfg_high_plim = PktLimitRst;
  logic [PktLimW-1:0]  cfg_low_plim  = PktLimitRst;
  logic [ByteLimW-1:0] cfg_high_blim = ByteLimitRst;
  logic [ByteLimW-1:0] cfg_low_blim  = ByteLimitRst;
  logic [PortW-1:0]    cfg_prio_port = PrioPortRst;

  logic [EntryW-1:0] high_fifo[$];
  logic [EntryW-1:0] low_fifo[$];
  int unsigned       high_bytes = 0;
  int unsigned       low_bytes  = 0;

  result_t expected_results[$];
  int      mismatches = 0;

  // Traffic shaping, percent of cycles.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // Long receiver hold-off: the test bumps hold_serial, the receiver takes it.
  int hold_request = 0;
  int hold_serial  = 0;
  int hold_taken   = 0;
  int hold_left    = 0;

  // Work out the result of one command and advance the model.
  function automatic result_t predict_result(cmd_beat_t c);
    result_t           r;
    logic              to_high;
    logic              admit;
    int unsigned       cnt;
    int unsigned       bytes;
    int unsigned       plim;
    int unsigned       blim;
    logic [EntryW-1:0] head;
    r = '0;
    case (c.func)
      OP_ENQUEUE: begin
        // no port means low class, whatever dest_port holds
        to_high = c.port_valid && (c.dest_port == cfg_prio_port);
        cnt     = to_high ? high_fifo.size() : low_fifo.size();
        bytes   = to_high ? high_bytes : low_bytes;
        plim    = to_high ? cfg_high_plim : cfg_low_plim;
        blim    = to_high ? cfg_high_blim : cfg_low_blim;
        if (cnt >= QDepth) begin
          admit = 1'b0;  // physical depth wins over any limit
        end else if (!cfg_by_bytes) begin
          admit = cnt < plim;
        end else begin
          admit = (bytes + c.pkt_len) < blim;
        end
        r.out_class = to_high ? ClassHigh : ClassLow;
        r.accepted  = admit;
        r.dropped   = !admit;
        if (admit && to_high) begin
          high_fifo.insert(high_fifo.size(), {c.pkt_tag, c.pkt_len});
          high_bytes += c.pkt_len;
        end else if (admit) begin
          low_fifo.insert(low_fifo.size(), {c.pkt_tag, c.pkt_len});
          low_bytes += c.pkt_len;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        // strict priority: high class drains first
        if (high_fifo.size() != 0) begin
          head        = high_fifo[0];
          r.out_valid = 1'b1;
          r.out_class = ClassHigh;
          if (c.func == OP_DEQUEUE) begin
            void'(high_fifo.pop_front());
            high_bytes = (high_bytes >= head[15:0]) ? high_bytes - head[15:0] : 0;
          end
        end else if (low_fifo.size() != 0) begin
          head        = low_fifo[0];
          r.out_valid = 1'b1;
          r.out_class = ClassLow;
          if (c.func == OP_DEQUEUE) begin
            void'(low_fifo.pop_front());
            low_bytes = (low_bytes >= head[15:0]) ? low_bytes - head[15:0] : 0;
          end
        end
        if (r.out_valid) begin
          r.out_tag = head[31:16];
          r.out_len = head[15:0];
        end
      end
      default: begin
        // unused code: all-zero result, no state change
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random or held-off tready, and the scoreboard.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_serial != hold_taken) begin
      hold_taken = hold_serial;
      hold_left  = hold_request;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[35:0]);
      if (expected_results.size() == 0) begin
        $error("result beat with no command outstanding: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("dropped", want.dropped, got.dropped);
        check_field("out_valid", want.out_valid, got.out_valid);
        check_field("out_class", want.out_class, got.out_class);
        check_field("out_tag", want.out_tag, got.out_tag);
        check_field("out_len", want.out_len, got.out_len);
        check_field("tdata_pad", 0, m_axis_tdata[39:36]);
      end
    end
  end

  // Watchdog: ends the run if no port moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends right after a rising edge.
  // ---------------------------------------------------------------------------
  function automatic void set_traffic(traffic_e mode);
    case (mode)
      TR_STEADY: begin
        src_idle_pct = 0; sink_stall_pct = 0;
      end
      TR_SENDER_GAPS: begin
        src_idle_pct = 59; sink_stall_pct = 0;
      end
      TR_RECEIVER_STALLS: begin
        src_idle_pct = 0; sink_stall_pct = 59;
      end
      default: begin
        src_idle_pct = 6; sink_stall_pct = 6;
      end
    endcase
  endfunction

  // APB write: setup, then access; the model copy follows the masked value.
  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    int unsigned mask;
    int unsigned kept;
    case (idx)
      REG_LIMIT_BY_BYTES:                          mask = 32'h1;
      REG_HIGH_PACKET_LIMIT, REG_LOW_PACKET_LIMIT: mask = 32'hFF;
      REG_HIGH_BYTE_LIMIT, REG_LOW_BYTE_LIMIT:     mask = 32'h7F_FFFF;
      default:                                     mask = 32'hFFFF;
    endcase
    kept = value & mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= kept | ($urandom() & ~mask);  // bits above the field must be ignored
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LIMIT_BY_BYTES:    cfg_by_bytes  = kept[0];
      REG_HIGH_PACKET_LIMIT: cfg_high_plim = kept[PktLimW-1:0];
      REG_LOW_PACKET_LIMIT:  cfg_low_plim  = kept[PktLimW-1:0];
      REG_HIGH_BYTE_LIMIT:   cfg_high_blim = kept[ByteLimW-1:0];
      REG_LOW_BYTE_LIMIT:    cfg_low_blim  = kept[ByteLimW-1:0];
      default:               cfg_prio_port = kept[PortW-1:0];
    endcase
  endtask

  // Offer one command beat, with random gaps ahead of it; predict at the handshake.
  task automatic send_cmd(cmd_beat_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, c.pkt_tag, c.pkt_len, c.dest_port, c.port_valid};
    s_axis_tuser  <= c.func;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_results.insert(expected_results.size(), predict_result(c));
  endtask

  // Stop offering and wait for every outstanding result beat.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  function automatic cmd_beat_t cmd_of(logic [1:0] func, logic pv, int unsigned dest,
                                       int unsigned len, int unsigned tag);
    cmd_beat_t c;
    c.func       = func;
    c.port_valid = pv;
    c.dest_port  = dest[15:0];
    c.pkt_len    = len[15:0];
    c.pkt_tag    = tag[15:0];
    return c;
  endfunction

  // Random command; high_pct steers enqueues at the priority port.
  function automatic cmd_beat_t random_cmd(int enq_pct, int peek_pct, int high_pct,
                                           int len_lo, int len_hi);
    cmd_beat_t c;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 2) begin
      c.func = OpUnused;
    end else if (roll < 2 + enq_pct) begin
      c.func = OP_ENQUEUE;
    end else if (roll < 2 + enq_pct + peek_pct) begin
      c.func = OP_PEEK;
    end else begin
      c.func = OP_DEQUEUE;
    end
    if ($urandom_range(99) < high_pct) begin
      c.port_valid = 1'b1;
      c.dest_port  = cfg_prio_port;
    end else begin
      // sometimes the priority port without a valid port: must land in low class
      c.port_valid = 1'($urandom_range(1));
      c.dest_port  = ($urandom_range(3) == 0) ? cfg_prio_port : 16'($urandom_range(65535));
    end
    c.pkt_len = 16'($urandom_range(len_hi, len_lo));
    c.pkt_tag = 16'($urandom());
    return c;
  endfunction

  task automatic run_random(int n, int enq_pct, int peek_pct, int high_pct,
                            int len_lo, int len_hi);
    repeat (n) send_cmd(random_cmd(enq_pct, peek_pct, high_pct, len_lo, len_hi));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: every op, empty queues, unused code, field extremes, priority order.
  task automatic test_directed_ops();
    wait_drain();
    set_traffic(TR_STEADY);
    send_cmd(cmd_of(OP_PEEK, 1'b0, 0, 0, 0));
    send_cmd(cmd_of(OP_DEQUEUE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_cmd(cmd_of(OpUnused, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_cmd(cmd_of(OpUnused, 1'b0, 0, 0, 0));
    send_cmd(cmd_of(OP_ENQUEUE, 1'b0, 3000, 0, 0));           // port absent
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 0, 1, 1));
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 2999, 7, 16'h5A5A));
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 3001, 16'h8000, 16'h8000));
    send_cmd(cmd_of(OP_PEEK, 1'b0, 0, 0, 0));
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 3000, 16'hFFFF, 16'hA5A5));  // high, after lows
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 3000, 0, 16'h0001));
    send_cmd(cmd_of(OP_PEEK, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_cmd(cmd_of(OP_DEQUEUE, 1'b0, 0, 0, 0));
    send_cmd(cmd_of(OP_DEQUEUE, 1'b0, 0, 0, 0));
    send_cmd(cmd_of(OP_PEEK, 1'b0, 0, 0, 0));
    repeat (5) send_cmd(cmd_of(OP_DEQUEUE, 1'b0, 0, 0, 0));
    send_cmd(cmd_of(OP_DEQUEUE, 1'b0, 0, 0, 0));              // both empty again
    send_cmd(cmd_of(OP_PEEK, 1'b0, 0, 0, 0));
  endtask

  // Byte bound is exclusive; zero limits drop everything.
  task automatic test_byte_bounds();
    wait_drain();
    write_reg(REG_LIMIT_BY_BYTES, 1);
    write_reg(REG_LOW_BYTE_LIMIT, 1000);
    write_reg(REG_HIGH_BYTE_LIMIT, 0);
    write_reg(REG_PRIORITY_PORT, 0);
    send_cmd(cmd_of(OP_ENQUEUE, 1'b0, 0, 999, 16'h1111));   // 999 < 1000: in
    send_cmd(cmd_of(OP_ENQUEUE, 1'b0, 0, 1, 16'h2222));     // total reaches bound: out
    send_cmd(cmd_of(OP_ENQUEUE, 1'b0, 0, 0, 16'h3333));     // zero length still fits
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 0, 0, 16'h4444));     // high bound zero: out
    repeat (3) send_cmd(cmd_of(OP_DEQUEUE, 1'b0, 0, 0, 0));
    wait_drain();
    write_reg(REG_LIMIT_BY_BYTES, 0);
    write_reg(REG_HIGH_PACKET_LIMIT, 0);
    write_reg(REG_LOW_PACKET_LIMIT, 1);
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 0, 5, 16'h5555));     // high limit zero
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 1, 5, 16'h6666));
    send_cmd(cmd_of(OP_ENQUEUE, 1'b1, 1, 5, 16'h7777));     // low limit reached
    send_cmd(cmd_of(OP_DEQUEUE, 1'b0, 0, 0, 0));
  endtask

  // Small packet limits, back-to-back beats.
  task automatic test_packet_limits();
    wait_drain();
    write_reg(REG_HIGH_PACKET_LIMIT, 4);
    write_reg(REG_LOW_PACKET_LIMIT, 6);
    write_reg(REG_PRIORITY_PORT, 16'h8000);
    set_traffic(TR_STEADY);
    run_random(250, 55, 10, 45, 0, 65535);
  endtask

  // High limit above the FIFO depth: the physical depth has to stop it.
  task automatic test_fill_to_depth();
    wait_drain();
    write_reg(REG_HIGH_PACKET_LIMIT, 255);
    write_reg(REG_LOW_PACKET_LIMIT, 128);
    write_reg(REG_PRIORITY_PORT, 16'hFFFF);
    set_traffic(TR_SENDER_GAPS);
    run_random(170, 100, 0, 85, 0, 65535);
    run_random(150, 5, 5, 50, 0, 65535);
  endtask

  task automatic test_byte_mode();
    wait_drain();
    write_reg(REG_LIMIT_BY_BYTES, 1);
    write_reg(REG_HIGH_BYTE_LIMIT, 200000);
    write_reg(REG_LOW_BYTE_LIMIT, 100000);
    write_reg(REG_PRIORITY_PORT, 0);
    set_traffic(TR_RECEIVER_STALLS);
    run_random(250, 55, 10, 40, 0, 65535);
  endtask

  // Byte mode at the largest bound: first the depth, then the byte total stops the class.
  task automatic test_byte_fill();
    wait_drain();
    write_reg(REG_HIGH_BYTE_LIMIT, 0);
    write_reg(REG_LOW_BYTE_LIMIT, 8388480);
    set_traffic(TR_BOTH);
    run_random(170, 100, 0, 10, 0, 15);
    run_random(160, 0, 5, 0, 0, 15);
    run_random(135, 100, 0, 0, 65535, 65535);
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    wait_drain();
    write_reg(REG_LIMIT_BY_BYTES, 0);
    write_reg(REG_HIGH_PACKET_LIMIT, 128);
    write_reg(REG_LOW_PACKET_LIMIT, 128);
    set_traffic(TR_STEADY);
    hold_request = LongHold;
    hold_serial++;
    run_random(80, 60, 10, 40, 0, 65535);
    wait_drain();  // sender pauses until every result is back
  endtask

  task automatic test_random_mix();
    traffic_e modes[3] = '{TR_RECEIVER_STALLS, TR_BOTH, TR_SENDER_GAPS};
    for (int round = 0; round < 3; round++) begin
      wait_drain();
      write_reg(REG_LIMIT_BY_BYTES, $urandom_range(1));
      write_reg(REG_HIGH_PACKET_LIMIT, $urandom_range(128));
      write_reg(REG_LOW_PACKET_LIMIT, $urandom_range(128, 20));
      write_reg(REG_HIGH_BYTE_LIMIT, $urandom_range(8388480));
      write_reg(REG_LOW_BYTE_LIMIT, $urandom_range(8388480, 100000));
      write_reg(REG_PRIORITY_PORT, $urandom_range(65535));
      set_traffic(modes[round]);
      run_random(150, 50, 10, 40, 0, 65535);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_ops();
    test_byte_bounds();
    test_packet_limits();
    test_fill_to_depth();
    test_byte_mode();
    test_byte_fill();
    test_backpressure();
    test_random_mix();
    wait_drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
